[hw/rtl/dpfrc_pkg.sv]
package dpfrc_pkg;

	localparam int ID_W   = 16;
	localparam int TIME_W = 32;
	localparam int CFG_W  = 11;
	localparam int CNT_W  = 11;

	localparam logic [1:0] MODE_ADD     = 2'd0;
	localparam logic [1:0] MODE_FORWARD = 2'd1;
	localparam logic [1:0] MODE_COUNT   = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ID_W-1:0]   source;
		logic [ID_W-1:0]   destination;
		logic [TIME_W-1:0] timestamp;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
	} req_t;

	typedef struct packed {
		logic              accepted;
		logic              packet_valid;
		logic [ID_W-1:0]   out_source;
		logic [ID_W-1:0]   out_destination;
		logic [TIME_W-1:0] out_timestamp;
		logic [CNT_W-1:0]  match_count;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]   src;
		logic [ID_W-1:0]   dst;
		logic [TIME_W-1:0] ts;
	} pkt_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_busy;
	} sts_t;

endpackage

[hw/rtl/dpfrc_ctrl.sv]
module dpfrc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  dpfrc_pkg::sts_t   sts,
	output dpfrc_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   stall_q;

	assign req_stall = stall_q;

	always_comb begin
		cmd.start  = (state_q == ST_IDLE) && req_valid;
		cmd.scan   = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_COMMIT) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_SCAN;
						stall_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

[hw/rtl/dpfrc_dp.sv]
module dpfrc_dp #(
	parameter int DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dpfrc_pkg::req_t               req,
	input  logic                          cfg_valid,
	input  logic [dpfrc_pkg::CFG_W-1:0]   cfg_data,
	output dpfrc_pkg::rsp_t               rsp,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  dpfrc_pkg::cmd_t               cmd,
	output dpfrc_pkg::sts_t               sts
);

	localparam int AW    = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int LIM_W = (OCC_W > dpfrc_pkg::CFG_W) ? OCC_W : dpfrc_pkg::CFG_W;

	dpfrc_pkg::pkt_t mem [DEPTH];

	logic [AW-1:0]              head_q;
	logic [AW-1:0]              tail_q;
	logic [OCC_W-1:0]           occ_q;
	logic [dpfrc_pkg::CFG_W-1:0] limit_q;

	dpfrc_pkg::req_t  req_q;
	logic [AW-1:0]    scan_ptr_q;
	logic [OCC_W-1:0] scan_left_q;
	logic             rd_vld_s1;
	dpfrc_pkg::pkt_t  rd_data_s1;
	logic             dup_q;
	logic [OCC_W-1:0] cnt_q;
	dpfrc_pkg::pkt_t  pkt_q;

	dpfrc_pkg::rsp_t  rsp_q;
	logic             rsp_valid_q;

	logic             rd_en;
	logic             wr_en;
	logic             hit_dup;
	logic             hit_cnt;
	logic [LIM_W-1:0] lim_eff;
	logic             evict;
	dpfrc_pkg::pkt_t  wr_pkt;
	dpfrc_pkg::rsp_t  rsp_d;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
		next_slot = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign rd_en = cmd.scan && (scan_left_q != '0);

	// Compare the entry read in the previous cycle against the request.
	assign hit_dup = (rd_data_s1.src == req_q.source) && (rd_data_s1.dst == req_q.destination)
		&& (rd_data_s1.ts == req_q.timestamp);
	assign hit_cnt = (rd_data_s1.dst == req_q.destination)
		&& (rd_data_s1.ts >= req_q.start_time) && (rd_data_s1.ts <= req_q.end_time);

	// A limit of zero acts as one and a limit beyond the store acts as its depth.
	always_comb begin
		if (limit_q == '0) begin
			lim_eff = LIM_W'(1);
		end else if (LIM_W'(limit_q) > LIM_W'(DEPTH)) begin
			lim_eff = LIM_W'(DEPTH);
		end else begin
			lim_eff = LIM_W'(limit_q);
		end
	end

	assign evict  = (LIM_W'(occ_q) >= lim_eff) && (occ_q != '0);
	assign wr_en  = cmd.commit && (req_q.mode == dpfrc_pkg::MODE_ADD) && !dup_q;
	assign wr_pkt = '{src: req_q.source, dst: req_q.destination, ts: req_q.timestamp};

	// Response for the request being committed; fields of other modes stay zero.
	always_comb begin
		rsp_d = '0;
		case (req_q.mode)
			dpfrc_pkg::MODE_ADD: begin
				rsp_d.accepted = !dup_q;
			end
			dpfrc_pkg::MODE_FORWARD: begin
				if (occ_q != '0) begin
					rsp_d.packet_valid    = 1'b1;
					rsp_d.out_source      = pkt_q.src;
					rsp_d.out_destination = pkt_q.dst;
					rsp_d.out_timestamp   = pkt_q.ts;
				end
			end
			dpfrc_pkg::MODE_COUNT: begin
				rsp_d.match_count = dpfrc_pkg::CNT_W'(cnt_q);
			end
			default: begin
			end
		endcase
	end

	assign sts.scan_done = (scan_left_q == '0) && !rd_vld_s1;
	assign sts.out_busy  = rsp_valid_q && rsp_stall;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= wr_pkt;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[scan_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= req;
		end
		if (rd_vld_s1) begin
			pkt_q <= rd_data_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			limit_q     <= dpfrc_pkg::CFG_W'(1024);
			scan_ptr_q  <= '0;
			scan_left_q <= '0;
			rd_vld_s1   <= 1'b0;
			dup_q       <= 1'b0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end

			if (cmd.start) begin
				scan_ptr_q <= head_q;
				dup_q      <= 1'b0;
				cnt_q      <= '0;
				case (req.mode) inside
					dpfrc_pkg::MODE_ADD, dpfrc_pkg::MODE_COUNT: scan_left_q <= occ_q;
					dpfrc_pkg::MODE_FORWARD: scan_left_q <= (occ_q != '0) ? OCC_W'(1) : '0;
					default: scan_left_q <= '0;
				endcase
			end else if (rd_en) begin
				scan_ptr_q  <= next_slot(scan_ptr_q);
				scan_left_q <= scan_left_q - 1'b1;
			end

			rd_vld_s1 <= rd_en;
			if (rd_vld_s1) begin
				if (hit_dup) begin
					dup_q <= 1'b1;
				end
				if (hit_cnt) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end

			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= rsp_d;
				case (req_q.mode)
					dpfrc_pkg::MODE_ADD: begin
						if (!dup_q) begin
							tail_q <= next_slot(tail_q);
							if (evict) begin
								head_q <= next_slot(head_q);
							end else begin
								occ_q <= occ_q + 1'b1;
							end
						end
					end
					dpfrc_pkg::MODE_FORWARD: begin
						if (occ_q != '0) begin
							head_q <= next_slot(head_q);
							occ_q  <= occ_q - 1'b1;
						end
					end
					default: begin
					end
				endcase
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		OCC_W'(occ_q) <= OCC_W'(DEPTH))
		else $error("occupancy exceeds store depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> (head_q == tail_q))
		else $error("empty store with head and tail apart");

	a_commit_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid_q)
		else $error("commit did not load the response register");

	a_rd_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(cmd.scan))
		else $error("store read outside a scan");

endmodule

[hw/rtl/dedup_packet_fifo_range_count_top.sv]
// Bounded packet queue with duplicate rejection and destination/time range counting.
//
// Requests arrive on req (valid/stall); a request is taken at a rising edge where
// req_valid is high and req_stall is low. Each request yields exactly one response
// on rsp (valid/stall), taken when rsp_valid is high and rsp_stall is low.
// An add walks every stored packet looking for an identical one and, if none is
// found, appends, evicting the oldest packet when the store holds the limit. A forward
// pops the oldest packet. A count walks every stored packet and counts matches.
// The single store read port sets the timing: an add or a count reads the stored
// packets one at a time and a forward reads only the oldest one before the response
// register is loaded; the controller then returns to idle before taking the next
// request. One request is in progress at a time; req_stall is high from acceptance
// until the response is loaded. A finished response may wait in its register while
// the next request is accepted; if the receiver still stalls when that request
// completes, it waits for the register to drain. The user must write the memory_limit
// register on the cfg channel (always ready) only while the block is idle; the block
// itself does not enforce this. Reset clears the queue pointers and occupancy and
// sets the limit to 1024; stored packets need no clearing.
module dedup_packet_fifo_range_count_top #(
	parameter int DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  dpfrc_pkg::req_t               req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output dpfrc_pkg::rsp_t               rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dpfrc_pkg::CFG_W-1:0]   cfg_data
);

	dpfrc_pkg::cmd_t cmd;
	dpfrc_pkg::sts_t sts;

	// The limit register is a plain flop, so a write is always taken.
	assign cfg_ready = 1'b1;

	dpfrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dpfrc_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
